### rtl/hrlp_pkg.sv
package hrlp_pkg;

    // Parser phases
    localparam logic [2:0] PH_LEAD    = 3'd0;
    localparam logic [2:0] PH_METHOD  = 3'd1;
    localparam logic [2:0] PH_PGAP    = 3'd2;
    localparam logic [2:0] PH_PATH    = 3'd3;
    localparam logic [2:0] PH_VGAP    = 3'd4;
    localparam logic [2:0] PH_VERSION = 3'd5;
    localparam logic [2:0] PH_VTRAIL  = 3'd6;
    localparam logic [2:0] PH_DISCARD = 3'd7;

    // Line status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BLANK       = 3'd1;
    localparam logic [2:0] ST_NO_MGAP     = 3'd2;
    localparam logic [2:0] ST_BAD_METHOD  = 3'd3;
    localparam logic [2:0] ST_NO_PATH     = 3'd4;
    localparam logic [2:0] ST_NO_PGAP     = 3'd5;
    localparam logic [2:0] ST_NO_VERSION  = 3'd6;
    localparam logic [2:0] ST_BAD_VERSION = 3'd7;

    // Method codes
    localparam logic [1:0] MC_GET   = 2'd0;
    localparam logic [1:0] MC_POST  = 2'd1;
    localparam logic [1:0] MC_UNSUP = 2'd2;
    localparam logic [1:0] MC_NONE  = 2'd3;

    // Version codes
    localparam logic [1:0] VC_10    = 2'd0;
    localparam logic [1:0] VC_11    = 2'd1;
    localparam logic [1:0] VC_UNSUP = 2'd2;
    localparam logic [1:0] VC_NONE  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] LEN_GET     = 4'd3;
    localparam logic [3:0] LEN_POST    = 4'd4;
    localparam logic [3:0] LEN_VERSION = 4'd8;

    // Candidate mask: bit 0 = GET / HTTP/1.0, bit 1 = POST / HTTP/1.1
    localparam logic [1:0] CAND_ALL  = 2'b11;
    localparam logic [1:0] CAND_NONE = 2'b00;

    typedef logic [2:0] t_phase;

    // Which method candidates accept byte b at position pos
    function automatic logic [1:0] method_hits(logic [3:0] pos, logic [7:0] b);
        logic [7:0] c_get;
        logic [7:0] c_post;
        case (pos)
            4'd0:    begin c_get = "G"; c_post = "P"; end
            4'd1:    begin c_get = "E"; c_post = "O"; end
            4'd2:    begin c_get = "T"; c_post = "S"; end
            4'd3:    begin c_get = 8'h00; c_post = "T"; end
            default: begin c_get = 8'h00; c_post = 8'h00; end
        endcase
        method_hits[0] = (pos < LEN_GET) && (b == c_get);
        method_hits[1] = (pos < LEN_POST) && (b == c_post);
    endfunction

    // Which version candidates accept byte b at position pos
    function automatic logic [1:0] version_hits(logic [3:0] pos, logic [7:0] b);
        logic [7:0] c_com;
        logic [7:0] c_10;
        logic [7:0] c_11;
        c_com = 8'h00;
        case (pos)
            4'd0:    c_com = "H";
            4'd1:    c_com = "T";
            4'd2:    c_com = "T";
            4'd3:    c_com = "P";
            4'd4:    c_com = "/";
            4'd5:    c_com = "1";
            4'd6:    c_com = ".";
            default: c_com = 8'h00;
        endcase
        c_10 = (pos == 4'd7) ? 8'h30 : c_com;
        c_11 = (pos == 4'd7) ? 8'h31 : c_com;
        version_hits[0] = (pos < LEN_VERSION) && (b == c_10);
        version_hits[1] = (pos < LEN_VERSION) && (b == c_11);
    endfunction

endpackage

### rtl/hrlp_line_if.sv
interface hrlp_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

### rtl/hrlp_result_if.sv
interface hrlp_result_if;
    logic       valid;
    logic       ready;
    logic       is_verdict;
    logic [7:0] path_byte;
    logic [2:0] line_status;
    logic [1:0] method_code;
    logic [1:0] version_code;

    modport source (output valid, output is_verdict, output path_byte, output line_status,
                    output method_code, output version_code, input ready);
    modport sink   (input valid, input is_verdict, input path_byte, input line_status,
                    input method_code, input version_code, output ready);
endinterface

### rtl/http_request_line_parser.sv
// Channel   Dir  Fields                                          Word
// i_line    in   line_byte[7:0], end_of_line                     one line byte
// o_result  out  is_verdict, path_byte[7:0], line_status[2:0],   path byte or verdict
//                method_code[1:0], version_code[1:0]
//
// One byte per cycle while no result is stalled; a result word appears in
// the cycle after its byte is taken. The throughput is set by the single
// phase/match update between the parser state registers and the output
// register. Reset (i_rst_n low, synchronous) returns the parser to
// leading-space skipping and empties the output register.
// A stalled result holds in the output register; a new byte is still taken in
// the cycle the held word leaves, and bytes without a result pass freely
// only while the output register is empty or draining.
module http_request_line_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hrlp_line_if.sink             i_line,
    hrlp_result_if.source         o_result
);

    // Parser state
    logic [2:0] r_phase,       n_phase;
    logic [3:0] r_match_pos,   n_match_pos;
    logic [1:0] r_cand,        n_cand;
    logic [1:0] r_method_seen, n_method_seen;
    logic [2:0] r_pend_fail,   n_pend_fail;

    // Output register
    logic       r_out_valid;
    logic       r_is_verdict;
    logic [7:0] r_path_byte;
    logic [2:0] r_line_status;
    logic [1:0] r_method_code;
    logic [1:0] r_version_code;

    logic       in_acc;
    logic       is_space;
    logic       emit_path;
    logic       emit;
    logic [3:0] pos_inc;
    logic [1:0] m_hits;
    logic [1:0] v_hits;
    logic [2:0] n_status;
    logic [1:0] n_mcode;
    logic [1:0] n_vcode;

    // Take a byte whenever the output register is empty or draining
    assign i_line.ready = !r_out_valid || o_result.ready;
    assign in_acc       = i_line.valid && i_line.ready;
    assign is_space     = (i_line.line_byte == hrlp_pkg::CH_SPACE);

    assign pos_inc = (r_match_pos < hrlp_pkg::POS_MAX) ? r_match_pos + 4'd1 : r_match_pos;
    assign m_hits  = hrlp_pkg::method_hits(r_match_pos, i_line.line_byte);
    assign v_hits  = hrlp_pkg::version_hits(r_match_pos, i_line.line_byte);

    // Phase update for one byte
    always_comb begin
        n_phase       = r_phase;
        n_match_pos   = r_match_pos;
        n_cand        = r_cand;
        n_method_seen = r_method_seen;
        n_pend_fail   = r_pend_fail;
        emit_path     = 1'b0;

        case (r_phase)
            hrlp_pkg::PH_LEAD: begin
                if (!is_space) begin
                    // First method byte starts a fresh token at position zero
                    n_match_pos = 4'd1;
                    n_cand      = hrlp_pkg::method_hits(4'd0, i_line.line_byte);
                    n_phase     = hrlp_pkg::PH_METHOD;
                end
            end
            hrlp_pkg::PH_METHOD: begin
                if (is_space) begin
                    if (r_cand[0] && r_match_pos == hrlp_pkg::LEN_GET) begin
                        n_method_seen = hrlp_pkg::MC_GET;
                        n_phase       = hrlp_pkg::PH_PGAP;
                    end else if (r_cand[1] && r_match_pos == hrlp_pkg::LEN_POST) begin
                        n_method_seen = hrlp_pkg::MC_POST;
                        n_phase       = hrlp_pkg::PH_PGAP;
                    end else begin
                        // Unknown method: drop the rest of the line
                        n_method_seen = hrlp_pkg::MC_UNSUP;
                        n_pend_fail   = hrlp_pkg::ST_BAD_METHOD;
                        n_phase       = hrlp_pkg::PH_DISCARD;
                    end
                end else begin
                    n_cand      = r_cand & m_hits;
                    n_match_pos = pos_inc;
                end
            end
            hrlp_pkg::PH_PGAP: begin
                if (!is_space) begin
                    n_phase   = hrlp_pkg::PH_PATH;
                    emit_path = 1'b1;
                end
            end
            hrlp_pkg::PH_PATH: begin
                if (is_space) begin
                    n_phase = hrlp_pkg::PH_VGAP;
                end else begin
                    emit_path = 1'b1;
                end
            end
            hrlp_pkg::PH_VGAP: begin
                if (!is_space) begin
                    n_match_pos = 4'd1;
                    n_cand      = hrlp_pkg::version_hits(4'd0, i_line.line_byte);
                    n_phase     = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_VERSION: begin
                if (is_space) begin
                    n_phase = hrlp_pkg::PH_VTRAIL;
                end else begin
                    n_cand      = r_cand & v_hits;
                    n_match_pos = pos_inc;
                end
            end
            hrlp_pkg::PH_VTRAIL: begin
                // A space inside the version kills both candidates
                if (!is_space) begin
                    n_cand  = hrlp_pkg::CAND_NONE;
                    n_phase = hrlp_pkg::PH_VERSION;
                end
            end
            default: begin
            end
        endcase
    end

    // Verdict from the updated state
    always_comb begin
        n_status = hrlp_pkg::ST_OK;
        n_mcode  = n_method_seen;
        n_vcode  = hrlp_pkg::VC_NONE;
        case (n_phase)
            hrlp_pkg::PH_LEAD: begin
                n_status = hrlp_pkg::ST_BLANK;
                n_mcode  = hrlp_pkg::MC_NONE;
            end
            hrlp_pkg::PH_METHOD: begin
                n_status = hrlp_pkg::ST_NO_MGAP;
                n_mcode  = hrlp_pkg::MC_NONE;
            end
            hrlp_pkg::PH_PGAP:  n_status = hrlp_pkg::ST_NO_PATH;
            hrlp_pkg::PH_PATH:  n_status = hrlp_pkg::ST_NO_PGAP;
            hrlp_pkg::PH_VGAP:  n_status = hrlp_pkg::ST_NO_VERSION;
            hrlp_pkg::PH_VERSION, hrlp_pkg::PH_VTRAIL: begin
                if (n_cand[0] && n_match_pos == hrlp_pkg::LEN_VERSION) begin
                    n_vcode = hrlp_pkg::VC_10;
                end else if (n_cand[1] && n_match_pos == hrlp_pkg::LEN_VERSION) begin
                    n_vcode = hrlp_pkg::VC_11;
                end else begin
                    n_status = hrlp_pkg::ST_BAD_VERSION;
                    n_vcode  = hrlp_pkg::VC_UNSUP;
                end
            end
            default: n_status = n_pend_fail;
        endcase
    end

    assign emit = i_line.end_of_line || emit_path;

    // State registers; the last byte of a line restores the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hrlp_pkg::PH_LEAD;
            r_match_pos   <= '0;
            r_cand        <= hrlp_pkg::CAND_ALL;
            r_method_seen <= hrlp_pkg::MC_NONE;
            r_pend_fail   <= hrlp_pkg::ST_OK;
        end else if (in_acc) begin
            if (i_line.end_of_line) begin
                r_phase       <= hrlp_pkg::PH_LEAD;
                r_match_pos   <= '0;
                r_cand        <= hrlp_pkg::CAND_ALL;
                r_method_seen <= hrlp_pkg::MC_NONE;
                r_pend_fail   <= hrlp_pkg::ST_OK;
            end else begin
                r_phase       <= n_phase;
                r_match_pos   <= n_match_pos;
                r_cand        <= n_cand;
                r_method_seen <= n_method_seen;
                r_pend_fail   <= n_pend_fail;
            end
        end
    end

    // Output valid: load on accept, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= emit;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; a verdict wins over a path byte on the last byte
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_line.end_of_line) begin
                r_is_verdict   <= 1'b1;
                r_path_byte    <= '0;
                r_line_status  <= n_status;
                r_method_code  <= n_mcode;
                r_version_code <= n_vcode;
            end else begin
                r_is_verdict   <= 1'b0;
                r_path_byte    <= i_line.line_byte;
                r_line_status  <= hrlp_pkg::ST_OK;
                r_method_code  <= n_method_seen;
                r_version_code <= hrlp_pkg::VC_NONE;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.is_verdict   = r_is_verdict;
    assign o_result.path_byte    = r_path_byte;
    assign o_result.line_status  = r_line_status;
    assign o_result.method_code  = r_method_code;
    assign o_result.version_code = r_version_code;

    // The last byte of a line leaves the parser in its reset state
    a_eol_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_line.end_of_line) |=>
            (r_phase == hrlp_pkg::PH_LEAD && r_match_pos == 4'd0 &&
             r_method_seen == hrlp_pkg::MC_NONE))
        else $error("parser state not cleared after end of line");

    // A path byte word carries a matched method and no version
    a_path_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_is_verdict) |->
            ((r_method_code == hrlp_pkg::MC_GET || r_method_code == hrlp_pkg::MC_POST) &&
             r_version_code == hrlp_pkg::VC_NONE && r_line_status == hrlp_pkg::ST_OK))
        else $error("path byte word with bad method or version fields");

    // Discard phase always follows a rejected method
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrlp_pkg::PH_DISCARD) |->
            (r_method_seen == hrlp_pkg::MC_UNSUP && r_pend_fail == hrlp_pkg::ST_BAD_METHOD))
        else $error("discard phase without a rejected method");

    // Path bytes are only reached once a method was accepted
    a_path_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hrlp_pkg::PH_PATH || r_phase == hrlp_pkg::PH_PGAP) |->
            (r_method_seen == hrlp_pkg::MC_GET || r_method_seen == hrlp_pkg::MC_POST))
        else $error("path phase without an accepted method");

endmodule

### tb/http_request_line_parser_tb.sv
`timescale 1ns / 100ps

module http_request_line_parser_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    // Quiet cycles allowed before the run is declared hung. A correct run with
    // both sides idling at random never comes near this.
    localparam int STALL_LIMIT  = 2000;
    // Wait after the last expected word is taken, left for the output register.
    localparam int DRAIN_CYCLES = 8;

    // One result word as seen on o_result
    typedef struct packed {
        logic       is_verdict;
        logic [7:0] path_byte;
        logic [2:0] line_status;
        logic [1:0] method_code;
        logic [1:0] version_code;
    } t_parse_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrlp_line_if   line_ch ();
    hrlp_result_if result_ch ();

    http_request_line_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (line_ch),
        .o_result (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Parser state mirrored by the testbench
    hrlp_pkg::t_phase parse_phase;
    logic [3:0] parse_pos;
    logic [1:0] parse_cand;
    logic [1:0] parse_method;
    logic [2:0] parse_fail;

    t_parse_word expected_words[$];
    logic [7:0]  line_q[$];

    int src_idle_pct  = 30;
    int sink_idle_pct = 52;
    int error_count   = 0;
    int quiet_cycles  = 0;
    int lines_sent    = 0;
    int bytes_sent    = 0;
    int path_checked  = 0;
    int verdicts_checked = 0;
    logic [7:0] status_seen = 8'h00;

    // ------------------------------------------------------------------
    // Line parser prediction
    // ------------------------------------------------------------------

    // Return to leading-space skipping with nothing matched yet.
    function automatic void clear_parse_state();
        parse_phase  = hrlp_pkg::PH_LEAD;
        parse_pos    = 4'd0;
        parse_cand   = hrlp_pkg::CAND_ALL;
        parse_method = hrlp_pkg::MC_NONE;
        parse_fail   = hrlp_pkg::ST_OK;
    endfunction

    // Drop each candidate that does not hold ch at the current position,
    // then advance the position, saturating at its maximum.
    function automatic void advance_match(string cand0, string cand1, logic [7:0] ch);
        int p;
        p = int'(parse_pos);
        if (!(p < cand0.len() && cand0[p] == ch))
            parse_cand[0] = 1'b0;
        if (!(p < cand1.len() && cand1[p] == ch))
            parse_cand[1] = 1'b0;
        if (parse_pos != hrlp_pkg::POS_MAX)
            parse_pos = parse_pos + 4'd1;
    endfunction

    // Consume one accepted line byte and queue the word it must produce.
    function automatic void parse_line_byte(logic [7:0] ch, logic eol);
        logic        is_space;
        logic        path_out;
        t_parse_word w;
        is_space = (ch == hrlp_pkg::CH_SPACE);
        path_out = 1'b0;

        case (parse_phase)
            hrlp_pkg::PH_LEAD: begin
                if (!is_space) begin
                    parse_pos  = 4'd0;
                    parse_cand = hrlp_pkg::CAND_ALL;
                    advance_match("GET", "POST", ch);
                    parse_phase = hrlp_pkg::PH_METHOD;
                end
            end
            hrlp_pkg::PH_METHOD: begin
                if (is_space) begin
                    if (parse_cand[0] && parse_pos == hrlp_pkg::LEN_GET) begin
                        parse_method = hrlp_pkg::MC_GET;
                        parse_phase  = hrlp_pkg::PH_PGAP;
                    end else if (parse_cand[1] && parse_pos == hrlp_pkg::LEN_POST) begin
                        parse_method = hrlp_pkg::MC_POST;
                        parse_phase  = hrlp_pkg::PH_PGAP;
                    end else begin
                        // Unknown method: swallow the rest of the line
                        parse_method = hrlp_pkg::MC_UNSUP;
                        parse_fail   = hrlp_pkg::ST_BAD_METHOD;
                        parse_phase  = hrlp_pkg::PH_DISCARD;
                    end
                end else begin
                    advance_match("GET", "POST", ch);
                end
            end
            hrlp_pkg::PH_PGAP: begin
                if (!is_space) begin
                    parse_phase = hrlp_pkg::PH_PATH;
                    path_out    = 1'b1;
                end
            end
            hrlp_pkg::PH_PATH: begin
                if (is_space)
                    parse_phase = hrlp_pkg::PH_VGAP;
                else
                    path_out = 1'b1;
            end
            hrlp_pkg::PH_VGAP: begin
                if (!is_space) begin
                    parse_pos  = 4'd0;
                    parse_cand = hrlp_pkg::CAND_ALL;
                    advance_match("HTTP/1.0", "HTTP/1.1", ch);
                    parse_phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_VERSION: begin
                if (is_space)
                    parse_phase = hrlp_pkg::PH_VTRAIL;
                else
                    advance_match("HTTP/1.0", "HTTP/1.1", ch);
            end
            hrlp_pkg::PH_VTRAIL: begin
                // Anything after the trailing spaces kills the version
                if (!is_space) begin
                    parse_cand  = hrlp_pkg::CAND_NONE;
                    parse_phase = hrlp_pkg::PH_VERSION;
                end
            end
            default: ;
        endcase

        if (!eol) begin
            if (path_out) begin
                w.is_verdict   = 1'b0;
                w.path_byte    = ch;
                w.line_status  = hrlp_pkg::ST_OK;
                w.method_code  = parse_method;
                w.version_code = hrlp_pkg::VC_NONE;
                expected_words.push_back(w);
            end
            return;
        end

        // Last byte: a verdict replaces any path word
        w.is_verdict   = 1'b1;
        w.path_byte    = 8'h00;
        w.line_status  = hrlp_pkg::ST_OK;
        w.method_code  = hrlp_pkg::MC_NONE;
        w.version_code = hrlp_pkg::VC_NONE;
        case (parse_phase)
            hrlp_pkg::PH_LEAD:   w.line_status = hrlp_pkg::ST_BLANK;
            hrlp_pkg::PH_METHOD: w.line_status = hrlp_pkg::ST_NO_MGAP;
            hrlp_pkg::PH_PGAP: begin
                w.line_status = hrlp_pkg::ST_NO_PATH;
                w.method_code = parse_method;
            end
            hrlp_pkg::PH_PATH: begin
                w.line_status = hrlp_pkg::ST_NO_PGAP;
                w.method_code = parse_method;
            end
            hrlp_pkg::PH_VGAP: begin
                w.line_status = hrlp_pkg::ST_NO_VERSION;
                w.method_code = parse_method;
            end
            hrlp_pkg::PH_VERSION, hrlp_pkg::PH_VTRAIL: begin
                w.method_code = parse_method;
                if (parse_cand[0] && parse_pos == hrlp_pkg::LEN_VERSION) begin
                    w.version_code = hrlp_pkg::VC_10;
                end else if (parse_cand[1] && parse_pos == hrlp_pkg::LEN_VERSION) begin
                    w.version_code = hrlp_pkg::VC_11;
                end else begin
                    w.line_status  = hrlp_pkg::ST_BAD_VERSION;
                    w.version_code = hrlp_pkg::VC_UNSUP;
                end
            end
            default: begin
                w.line_status = parse_fail;
                w.method_code = parse_method;
            end
        endcase
        expected_words.push_back(w);
        clear_parse_state();
    endfunction

    // ------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------

    function automatic logic [7:0] nonspace_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == hrlp_pkg::CH_SPACE);
        return b;
    endfunction

    function automatic void push_text(string text);
        for (int k = 0; k < text.len(); k++)
            line_q.push_back(text[k]);
    endfunction

    function automatic void push_spaces(int count);
        repeat (count) line_q.push_back(hrlp_pkg::CH_SPACE);
    endfunction

    // Push a keyword, either intact or damaged in one of several ways.
    function automatic void push_token(string word, logic mangle);
        int at;
        int n;
        if (!mangle) begin
            push_text(word);
            return;
        end
        case ($urandom_range(3))
            0: begin
                // corrupt one character
                at = $urandom_range(word.len() - 1);
                for (int k = 0; k < word.len(); k++)
                    line_q.push_back((k == at) ? nonspace_byte() : word[k]);
            end
            1: push_text(word.substr(0, $urandom_range(word.len() - 2)));
            2: begin
                // one to three bytes too many, often a repeat of the last letter
                push_text(word);
                if ($urandom_range(1))
                    line_q.push_back(word[word.len() - 1]);
                else
                    line_q.push_back(nonspace_byte());
                repeat ($urandom_range(2)) line_q.push_back(nonspace_byte());
            end
            default: begin
                // run the match position up to or into saturation
                push_text(word);
                n = $urandom_range(14, 18) - word.len();
                repeat (n) line_q.push_back(nonspace_byte());
            end
        endcase
    endfunction

    function automatic void push_version();
        string word;
        int    sel;
        int    at;
        word = $urandom_range(1) ? "HTTP/1.1" : "HTTP/1.0";
        sel  = $urandom_range(9);
        if (sel == 0) begin
            // space inside the version
            at = $urandom_range(1, 7);
            push_text(word.substr(0, at - 1));
            push_spaces($urandom_range(1, 2));
            push_text(word.substr(at, 7));
        end else begin
            push_token(word, sel <= 2);
        end
    endfunction

    // Mostly request lines with random content; some cut short, some noise.
    function automatic void build_random_line();
        int pick;
        int cut;
        logic [7:0] b;
        line_q.delete();
        pick = $urandom_range(99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 12)) begin
                b = ($urandom_range(3) == 0) ? hrlp_pkg::CH_SPACE : 8'($urandom_range(255));
                line_q.push_back(b);
            end
            return;
        end
        push_spaces(($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0);
        push_token($urandom_range(1) ? "GET" : "POST", $urandom_range(7) == 0);
        push_spaces($urandom_range(1, 3));
        repeat ($urandom_range(1, 6)) line_q.push_back(nonspace_byte());
        push_spaces($urandom_range(1, 2));
        push_version();
        push_spaces($urandom_range(2));
        if ($urandom_range(11) == 0)
            line_q.push_back(nonspace_byte());
        if (pick < 30) begin
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut)
                void'(line_q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one byte; return at the edge that takes it. Must be entered at a
    // rising edge, and leaves valid high for the next caller to decide.
    task automatic send_byte(input logic [7:0] ch, input logic eol);
        while ($urandom_range(99) < src_idle_pct) begin
            line_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_ch.valid       <= 1'b1;
        line_ch.line_byte   <= ch;
        line_ch.end_of_line <= eol;
        do
            @(posedge i_clk);
        while (!line_ch.ready);
        parse_line_byte(ch, eol);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line_q.size(); k++)
            send_byte(line_q[k], k == line_q.size() - 1);
        lines_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lines that fail before the version: blank, unfinished method, bad
    // method, missing path, path that runs into the end of the line.
    task automatic test_framing_errors();
        line_q.delete();
        push_spaces(1);
        send_line();

        line_q.delete();
        line_q.push_back(8'hFF);
        send_line();

        // over-long method; the rest of the line is swallowed
        line_q.delete();
        push_text("GETT ");
        line_q.push_back(8'h00);
        send_line();

        line_q.delete();
        push_text("GET ");
        send_line();

        // the last path byte gives only the verdict
        line_q.delete();
        push_text("POST ");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        send_line();
    endtask

    task automatic test_random_lines(input int src_pct, input int sink_pct,
                                     input int byte_budget);
        int stop_at;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            build_random_line();
            send_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and hang detection
    // ------------------------------------------------------------------

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_parse_word want;
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                quiet_cycles = 0;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: verdict %0b path %0d status %0d",
                           result_ch.is_verdict, result_ch.path_byte, result_ch.line_status);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("is_verdict", want.is_verdict, result_ch.is_verdict);
                    compare_field("path_byte", want.path_byte, result_ch.path_byte);
                    compare_field("line_status", want.line_status, result_ch.line_status);
                    compare_field("method_code", want.method_code, result_ch.method_code);
                    compare_field("version_code", want.version_code,
                                  result_ch.version_code);
                    if (want.is_verdict) begin
                        verdicts_checked++;
                        status_seen[want.line_status] = 1'b1;
                    end else begin
                        path_checked++;
                    end
                end
            end else if (line_ch.valid && line_ch.ready) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $error("no word moved for %0d cycles, %0d results outstanding",
                           STALL_LIMIT, expected_words.size());
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n             = 1'b0;
        line_ch.valid       = 1'b0;
        line_ch.line_byte   = 8'h00;
        line_ch.end_of_line = 1'b0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_framing_errors();
        test_random_lines(30, 52, 410);
        test_random_lines(52, 30, 410);
        test_random_lines(0, 0, 410);

        // Stop offering bytes, then let the last results drain.
        line_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request lines (%0d bytes) under three idling mixes.",
                 lines_sent, bytes_sent);
        $display("Checked %0d path words and %0d verdicts; status codes hit: %b",
                 path_checked, verdicts_checked, status_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
